/* rtl/core/prs_pkg.sv */
// Shared types and constants of the prime-removing stream filter.
`timescale 1ns / 1ps

package prs_pkg;

  localparam int VAL_W     = 32;
  localparam int U_W       = VAL_W - 1;
  localparam int DIV_W     = 16;
  localparam int SQ_W      = 32;
  localparam int REM_STEPS = U_W;
  localparam int STEP_W    = $clog2(REM_STEPS);
  localparam int MAX_ITEMS = 1024;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;

  typedef struct packed {
    logic             start;
    logic [U_W-1:0]   dividend;
    logic [DIV_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

  typedef struct packed {
    logic valid;
    logic prime;
  } verdict_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } ctrl_state_t;

endpackage

/* rtl/core/prs_if.sv */
// Request and result channel interfaces of the prime-removing stream filter.
`timescale 1ns / 1ps

interface prs_in_if;
  logic        valid;
  logic        ready;
  logic signed [prs_pkg::VAL_W-1:0] value;
  logic        last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface prs_out_if;
  logic        valid;
  logic        ready;
  logic signed [prs_pkg::VAL_W-1:0] value_out;
  logic        keep;
  logic [prs_pkg::IDX_W-1:0] write_index;
  logic [prs_pkg::CNT_W-1:0] kept_count;
  logic        last_out;

  modport source (output valid, output value_out, output keep, output write_index,
                  output kept_count, output last_out, input ready);
  modport sink   (input valid, input value_out, input keep, input write_index,
                  input kept_count, input last_out, output ready);
endinterface

/* rtl/core/prs_rem_unit.sv */
// Bit-serial restoring remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps

module prs_rem_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  prs_pkg::rem_req_t req,
  output prs_pkg::rem_rsp_t rsp
);
  import prs_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [U_W-1:0]    shf_r, shf_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;

  assign trial = {rem_r, shf_r[U_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    shf_nxt  = shf_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      shf_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      shf_nxt = {shf_r[U_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DIV_W-1:0];
      end else begin
        rem_nxt = trial[DIV_W-1:0];
      end
      if (step_r == STEP_W'(REM_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    shf_r <= shf_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.zero = (rem_r == '0);

endmodule

/* rtl/core/prs_ctrl.sv */
// Trial-division sequencer: steps the divisor and its square, drives the remainder unit.
`timescale 1ns / 1ps

module prs_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_go,
  input  logic signed [prs_pkg::VAL_W-1:0] item_value,
  input  logic                            out_take,
  output logic                            idle,
  output prs_pkg::verdict_t               verdict,
  output prs_pkg::rem_req_t               rem_req,
  input  prs_pkg::rem_rsp_t               rem_rsp
);
  import prs_pkg::*;

  ctrl_state_t      state_r, state_nxt;
  logic [U_W-1:0]   u_r, u_nxt;
  logic [DIV_W-1:0] d_r, d_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic             prime_r, prime_nxt;
  logic             small_val;
  logic             rem_start;

  assign small_val = item_value[VAL_W-1] || (item_value[VAL_W-2:1] == '0);

  always_comb begin
    state_nxt = state_r;
    u_nxt     = u_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    prime_nxt = prime_r;
    rem_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (item_go) begin
          u_nxt  = item_value[U_W-1:0];
          d_nxt  = DIV_W'(2);
          sq_nxt = SQ_W'(4);
          if (small_val) begin
            prime_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_r > {1'b0, u_r}) begin
          prime_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          rem_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_rsp.done) begin
          if (rem_rsp.zero) begin
            prime_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            d_nxt     = d_r + 1'b1;
            sq_nxt    = sq_r + SQ_W'({d_r, 1'b1});
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (out_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    u_r     <= u_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    prime_r <= prime_nxt;
  end

  assign idle             = (state_r == ST_IDLE);
  assign verdict.valid    = (state_r == ST_DONE);
  assign verdict.prime    = prime_r;
  assign rem_req.start    = rem_start;
  assign rem_req.dividend = u_r;
  assign rem_req.divisor  = d_r;

endmodule

/* rtl/core/prime_removing_stream_filter_top.sv */
// Top level of the prime-removing stream filter: handshakes, kept counter, result register.
//
//  channel  | direction | handshake     | payload
//  in_chan  | sink      | valid / ready | value, last
//  out_chan | source    | valid / ready | value_out, keep, write_index, kept_count, last_out
//
// One request at a time; in_chan.ready is low from acceptance until its result is loaded.
// Values of 1 or less skip trial division; otherwise each trial divisor d (2, 3, ... while
// d*d <= value) takes one pass through the single 31-step remainder unit. A new request
// is taken while a result waits on out_chan.
// Reset (rst_n low, synchronous) clears the kept counter and empties the result register.
`timescale 1ns / 1ps

module prime_removing_stream_filter_top (
  input  logic      clk,
  input  logic      rst_n,
  prs_in_if.sink    in_chan,
  prs_out_if.source out_chan
);
  import prs_pkg::*;

  logic                    ctrl_idle;
  verdict_t                verdict;
  rem_req_t                rem_req;
  rem_rsp_t                rem_rsp;
  logic                    in_acc;
  logic                    load;
  logic                    keep;
  logic signed [VAL_W-1:0] item_value_r;
  logic                    item_last_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        cnt_new;
  logic [IDX_W-1:0]        widx;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_keep_r;
  logic [IDX_W-1:0]        out_widx_r;
  logic [CNT_W-1:0]        out_cnt_r;
  logic                    out_last_r;

  assign in_chan.ready = ctrl_idle;
  assign in_acc        = in_chan.valid && ctrl_idle;
  assign load          = verdict.valid && (!out_valid_r || out_chan.ready);
  assign keep          = !verdict.prime;

  prs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_go    (in_acc),
    .item_value (in_chan.value),
    .out_take   (load),
    .idle       (ctrl_idle),
    .verdict    (verdict),
    .rem_req    (rem_req),
    .rem_rsp    (rem_rsp)
  );

  prs_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  always_comb begin
    widx    = '0;
    cnt_new = cnt_r;
    if (keep) begin
      if (cnt_r >= CNT_W'(MAX_ITEMS)) begin
        widx    = IDX_W'(MAX_ITEMS - 1);
        cnt_new = CNT_W'(MAX_ITEMS);
      end else begin
        widx    = cnt_r[IDX_W-1:0];
        cnt_new = cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      cnt_nxt       = item_last_r ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      item_value_r <= in_chan.value;
      item_last_r  <= in_chan.last;
    end
    if (load) begin
      out_value_r <= item_value_r;
      out_keep_r  <= keep;
      out_widx_r  <= widx;
      out_cnt_r   <= cnt_new;
      out_last_r  <= item_last_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.value_out   = out_value_r;
  assign out_chan.keep        = out_keep_r;
  assign out_chan.write_index = out_widx_r;
  assign out_chan.kept_count  = out_cnt_r;
  assign out_chan.last_out    = out_last_r;

endmodule
